>>> hdl/nev_pkg.sv
// ============================================================================
// Neville interpolator package
// Shared types, codes and saturation helpers for the interpolator core.
// ============================================================================
package nev_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_READY = 2'd1,
        STAT_DUP       = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEAR,
        S_Y0,
        S_HO,
        S_HP,
        S_DEN,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COL,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_STORE,
        OP_QUERY,
        OP_NEAR,
        OP_Y0,
        OP_HO,
        OP_HP,
        OP_DEN,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_COL,
        OP_OUT_OK,
        OP_OUT_NR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   col_upper;
    } t_dp_cmd;

    typedef struct packed {
        logic closer;
        logic div_done;
    } t_dp_stat;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? S32_MIN : S32_MAX;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < 64'shFFFF_FFFF_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/nev_if.sv
// ============================================================================
// Neville interpolator channels
// Valid/ready channels for input words and result words.
// ============================================================================
interface nev_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;

    modport source (output valid, output action, output x_coord, output y_coord,
                    input ready);
    modport sink   (input valid, input action, input x_coord, input y_coord,
                    output ready);
endinterface

interface nev_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] estimate;
    logic signed [31:0] error_estimate;
    logic [1:0]         status;

    modport source (output valid, output estimate, output error_estimate,
                    output status, input ready);
    modport sink   (input valid, input estimate, input error_estimate,
                    input status, output ready);
endinterface

>>> hdl/nev_div.sv
// ============================================================================
// Neville interpolator divider
// Restoring divider for (num << FRAC_BITS) / den, one quotient bit a cycle,
// truncating toward zero and saturating to 32 bits.
// ============================================================================
module nev_div
    import nev_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quo
);

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] MAG_NEG_LIM = NUM_W'(64'h8000_0000);
    localparam logic [NUM_W-1:0] MAG_POS_LIM = NUM_W'(64'h7FFF_FFFF);

    logic                     r_busy;
    logic                     r_fin;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [NUM_W-1:0]         r_quo;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_dmag;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_q;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign num_mag = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
    assign trial   = {r_rem, r_quo[NUM_W-1]};
    assign fits    = trial >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    // Equal abscissas: saturate by the sign of the numerator.
                    if (i_num > 0) begin
                        r_q <= S32_MAX;
                    end else if (i_num < 0) begin
                        r_q <= S32_MIN;
                    end else begin
                        r_q <= '0;
                    end
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(NUM_W);
                    r_quo  <= {num_mag, {FRAC_BITS{1'b0}}};
                    r_rem  <= '0;
                    r_dmag <= den_mag;
                    r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                end
            end else if (r_busy) begin
                r_rem <= fits ? DATA_W'(trial - {1'b0, r_dmag}) : trial[DATA_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (r_neg) begin
                    r_q <= (r_quo > MAG_NEG_LIM) ? S32_MIN : -$signed(r_quo[DATA_W-1:0]);
                end else begin
                    r_q <= (r_quo > MAG_POS_LIM) ? S32_MAX : $signed(r_quo[DATA_W-1:0]);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> hdl/nev_dp.sv
// ============================================================================
// Neville interpolator datapath
// Point stores, correction tables, subtractors, divider, multiplier and the
// running estimate, steered by commands from the controller.
// ============================================================================
module nev_dp
    import nev_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int FRAC_BITS  = 16,
    parameter int IDX_W      = $clog2(MAX_POINTS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [IDX_W-1:0]         i_a,
    input  logic [IDX_W-1:0]         i_b,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    output t_dp_stat                 o_stat,
    output logic signed [DATA_W-1:0] o_estimate,
    output logic signed [DATA_W-1:0] o_error_estimate,
    output logic [1:0]               o_status
);

    logic signed [DATA_W-1:0] r_xs [MAX_POINTS];
    logic signed [DATA_W-1:0] r_ys [MAX_POINTS];
    logic signed [DATA_W-1:0] r_cu [MAX_POINTS];
    logic signed [DATA_W-1:0] r_dl [MAX_POINTS];

    logic signed [DATA_W-1:0] r_xq, r_ho, r_hp, r_w, r_y, r_dy;
    logic signed [63:0]       r_prod;
    logic [DATA_W:0]          r_best;
    logic                     r_dup;
    logic signed [DATA_W-1:0] r_est, r_err;
    t_status                  r_status;

    logic signed [DATA_W-1:0] x_rd, y_rd, c_rd, d_rd;
    logic signed [DATA_W:0]   gap_s;
    logic [DATA_W:0]          gap;
    logic signed [DATA_W-1:0] x_off, den, mul_a, mul_res, dy_sel, quo;
    logic signed [63:0]       prod_c, prod_sh;
    logic                     div_done;

    assign x_rd = r_xs[i_a];
    assign y_rd = r_ys[i_a];
    assign c_rd = r_cu[i_b];
    assign d_rd = r_dl[i_a];

    assign gap_s = {r_xq[DATA_W-1], r_xq} - {x_rd[DATA_W-1], x_rd};
    assign gap   = gap_s[DATA_W] ? (DATA_W+1)'(-gap_s) : gap_s;
    assign x_off = sat33({x_rd[DATA_W-1], x_rd} - {r_xq[DATA_W-1], r_xq});
    assign den   = sat33({r_ho[DATA_W-1], r_ho} - {r_hp[DATA_W-1], r_hp});

    nev_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DEN),
        .i_num   (r_w),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign mul_a   = (i_cmd.op == OP_MUL2) ? r_ho : r_hp;
    assign prod_c  = mul_a * quo;
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign mul_res = sat64(prod_sh);
    assign dy_sel  = i_cmd.col_upper ? c_rd : d_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_QUERY: r_dup <= 1'b0;
                OP_DEN:   if (den == '0) begin
                    r_dup <= 1'b1;
                end
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_STORE: begin
                r_xs[i_a] <= i_x;
                r_ys[i_a] <= i_y;
            end
            OP_QUERY: r_xq <= i_x;
            OP_NEAR: begin
                r_cu[i_a] <= y_rd;
                r_dl[i_a] <= y_rd;
                if (i_a == '0 || gap < r_best) begin
                    r_best <= gap;
                end
            end
            OP_Y0:    r_y <= y_rd;
            OP_HO: begin
                r_ho <= x_off;
                r_w  <= sat33({c_rd[DATA_W-1], c_rd} - {d_rd[DATA_W-1], d_rd});
            end
            OP_HP:    r_hp <= x_off;
            OP_MUL1:  r_prod <= prod_c;
            OP_MUL2: begin
                r_dl[i_a] <= mul_res;
                r_prod    <= prod_c;
            end
            OP_MUL3:  r_cu[i_a] <= mul_res;
            OP_COL: begin
                r_dy <= dy_sel;
                r_y  <= sat33({r_y[DATA_W-1], r_y} + {dy_sel[DATA_W-1], dy_sel});
            end
            OP_OUT_OK: begin
                r_est    <= r_y;
                r_err    <= r_dy;
                r_status <= r_dup ? STAT_DUP : STAT_OK;
            end
            OP_OUT_NR: begin
                r_est    <= '0;
                r_err    <= '0;
                r_status <= STAT_NOT_READY;
            end
            default: ;
        endcase
    end

    assign o_stat.closer   = gap < r_best;
    assign o_stat.div_done = div_done;

    assign o_estimate       = r_est;
    assign o_error_estimate = r_err;
    assign o_status         = r_status;

endmodule

>>> hdl/nev_ctrl.sv
// ============================================================================
// Neville interpolator controller
// Sequences the nearest-point search and the tableau columns, holds the
// configuration register, the point count and the result handshake.
// ============================================================================
module nev_ctrl
    import nev_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int IDX_W      = $clog2(MAX_POINTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_a,
    output logic [IDX_W-1:0] o_b
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_pu;
    logic [CNT_W-1:0] r_loaded, n_loaded;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_i, n_i, r_m, n_m, r_s, n_s, r_near, n_near;
    logic             r_nr, n_nr;
    logic             r_out_valid;

    logic             accept;
    logic [CNT_W-1:0] n_clamp;
    logic [CNT_W-1:0] i_plus1, n_minus_m;
    logic             col_upper;
    logic             out_free;
    logic             out_load;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_pu < CFG_W'(2)) begin
            n_clamp = CNT_W'(2);
        end else if (int'(r_pu) > MAX_POINTS) begin
            n_clamp = CNT_W'(MAX_POINTS);
        end else begin
            n_clamp = CNT_W'(r_pu);
        end
    end

    assign i_plus1   = CNT_W'(r_i) + 1'b1;
    assign n_minus_m = r_n - CNT_W'(r_m);
    assign col_upper = ((CNT_W+1)'(r_s) << 1) < (CNT_W+1)'(n_minus_m) || r_s == '0;

    // Next state and loop counters.
    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_n      = r_n;
        n_i      = r_i;
        n_m      = r_m;
        n_s      = r_s;
        n_near   = r_near;
        n_nr     = r_nr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in_action) begin
                        if (r_loaded < CNT_W'(MAX_POINTS)) begin
                            n_loaded = r_loaded + 1'b1;
                        end
                    end else begin
                        n_n = n_clamp;
                        n_i = '0;
                        if (r_loaded < n_clamp) begin
                            n_nr    = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_nr    = 1'b0;
                            n_state = S_NEAR;
                        end
                    end
                end
            end
            S_NEAR: begin
                if (r_i == '0 || i_stat.closer) begin
                    n_near = r_i;
                end
                if (i_plus1 == r_n) begin
                    n_state = S_Y0;
                end else begin
                    n_i = IDX_W'(i_plus1);
                end
            end
            S_Y0: begin
                n_s     = r_near;
                n_m     = IDX_W'(1);
                n_i     = '0;
                n_state = S_HO;
            end
            S_HO:   n_state = S_HP;
            S_HP:   n_state = S_DEN;
            S_DEN:  n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: begin
                if (i_plus1 < n_minus_m) begin
                    n_i     = IDX_W'(i_plus1);
                    n_state = S_HO;
                end else begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                if (!col_upper) begin
                    n_s = r_s - 1'b1;
                end
                if (CNT_W'(r_m) + 1'b1 < r_n) begin
                    n_m     = r_m + 1'b1;
                    n_i     = '0;
                    n_state = S_HO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands, indexes and handshake outputs.
    always_comb begin
        o_cmd.op        = OP_NOP;
        o_cmd.col_upper = col_upper;
        o_a             = r_i;
        o_b             = IDX_W'(i_plus1);
        o_in_ready      = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_a        = r_loaded[IDX_W-1:0];
                if (accept) begin
                    if (!i_in_action) begin
                        if (r_loaded < CNT_W'(MAX_POINTS)) begin
                            o_cmd.op = OP_STORE;
                        end
                    end else begin
                        o_cmd.op = OP_QUERY;
                    end
                end
            end
            S_NEAR: o_cmd.op = OP_NEAR;
            S_Y0: begin
                o_cmd.op = OP_Y0;
                o_a      = r_near;
            end
            S_HO:   o_cmd.op = OP_HO;
            S_HP: begin
                o_cmd.op = OP_HP;
                o_a      = r_i + r_m;
            end
            S_DEN:  o_cmd.op = OP_DEN;
            S_DIV:  o_cmd.op = OP_NOP;
            S_MUL1: o_cmd.op = OP_MUL1;
            S_MUL2: o_cmd.op = OP_MUL2;
            S_MUL3: o_cmd.op = OP_MUL3;
            S_COL: begin
                o_cmd.op = OP_COL;
                o_a      = (r_s == '0) ? '0 : r_s - 1'b1;
                o_b      = r_s;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    o_cmd.op = r_nr ? OP_OUT_NR : OP_OUT_OK;
                end
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pu        <= CFG_W'(4);
            r_loaded    <= '0;
            r_out_valid <= 1'b0;
            r_nr        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_nr     <= n_nr;
            if (i_cfg_we) begin
                r_pu <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_i    <= n_i;
        r_m    <= n_m;
        r_s    <= n_s;
        r_near <= n_near;
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COL |-> (CNT_W'(r_m) < r_n && CNT_W'(r_s) < r_n))
        else $error("tableau column or path index out of range");

    a_den_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEN |=> r_state == S_DIV)
        else $error("divider start not followed by wait");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending result dropped while stalled");
`endif

endmodule

>>> hdl/neville_polynomial_interpolator_core.sv
// ============================================================================
// Neville polynomial interpolator core
// Loads points, then evaluates the interpolating polynomial at a query point
// in signed fixed point with saturation.
// ============================================================================
// Usage:
// Input words arrive on i_in. A word with action 0 stores (x_coord, y_coord)
// in the next free slot; once the store is full further loads are dropped.
// A word with action 1 evaluates at x_coord over the first points_used points
// and yields one result word on o_out: estimate, error_estimate and status.
// Loads yield no result word. points_used is clamped to 2..MAX_POINTS.
// An evaluation runs the bit-serial divider once for each tableau entry;
// values are signed Q16.16 with the default FRAC_BITS. Too few points
// loaded gives a not_ready result word.
// One word is in work at a time; ready is high while the controller is idle,
// even when a finished result word still waits in the output register.
// A stalled receiver holds the result word; the next evaluation waits at its
// end until the output register is free.
// Synchronous active-low reset empties the point store, drops any pending
// result and sets points_used to 4. The user must write points_used through
// i_cfg_we and i_cfg_wdata only while the core is idle; it is not enforced.
// ============================================================================
module neville_polynomial_interpolator_core
    import nev_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    nev_in_if.sink           i_in,
    nev_out_if.source        o_out
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    // Command and status bundles between the sequencer and the datapath.
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;

    // The controller walks the nearest-point sweep and then each tableau
    // entry column by column; the datapath does the arithmetic.
    nev_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_a         (idx_a),
        .o_b         (idx_b)
    );

    nev_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_a              (idx_a),
        .i_b              (idx_b),
        .i_x              (i_in.x_coord),
        .i_y              (i_in.y_coord),
        .o_stat           (stat),
        .o_estimate       (o_out.estimate),
        .o_error_estimate (o_out.error_estimate),
        .o_status         (o_out.status)
    );

endmodule
